/* rtl/rtp_pkg.sv */
// Shared widths, codes and control types of the recalibration trigger policy.
package rtp_pkg;

   localparam int ACTION_W    = 2;
   localparam int TIME_W      = 32;
   localparam int TEMP_W      = 16;
   localparam int CAUSE_W     = 2;
   localparam int DRIFT_W     = 17;
   localparam int ITC_W       = 22;
   localparam int THR_W       = 15;
   localparam int WEIGHT_W    = 17;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 5;
   localparam int REG_INDEX_W = CSR_ADDR_W - 2;

   localparam int WEIGHT_TABLE_DEPTH_DEFAULT = 256;

   typedef enum logic [ACTION_W-1:0] {
      ACT_FRAME       = 2'd0,
      ACT_CAL_DONE    = 2'd1,
      ACT_LOCKOUT_END = 2'd2
   } action_type;

   typedef enum logic [CAUSE_W-1:0] {
      CAUSE_NONE         = 2'd0,
      CAUSE_DRIFT        = 2'd1,
      CAUSE_MAX_INTERVAL = 2'd2
   } cause_type;

   // Register index; the byte address is four times the index.
   typedef enum logic [REG_INDEX_W-1:0] {
      REG_POLICY_ENABLED    = 3'd0,
      REG_INV_TIME_CONSTANT = 3'd1,
      REG_MIN_INTERVAL      = 3'd2,
      REG_MAX_INTERVAL      = 3'd3,
      REG_AFTER_LOCKOUT     = 3'd4,
      REG_RETRY             = 3'd5,
      REG_DRIFT_THRESHOLD   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic              policy_enabled;
      logic [ITC_W-1:0]  inv_time_constant;
      logic [TIME_W-1:0] min_interval_ms;
      logic [TIME_W-1:0] max_interval_ms;
      logic [TIME_W-1:0] after_lockout_ms;
      logic [TIME_W-1:0] retry_ms;
      logic [THR_W-1:0]  drift_threshold;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic index_mul;
      logic weight_rd;
      logic blend_mul;
      logic apply;
      logic check;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic blend_path;
      logic out_free;
   } dp_sts_type;

endpackage

/* rtl/rtp_req_if.sv */
// Input channel carrying frame checks and calibration or lockout events.
interface rtp_req_if;
   logic                              valid;
   logic                              ready;
   logic [rtp_pkg::ACTION_W-1:0]      action;
   logic [rtp_pkg::TIME_W-1:0]        time_ms;
   logic signed [rtp_pkg::TEMP_W-1:0] fpa_temp;
   logic                              fpa_valid;
   logic                              blocked;

   modport source (output valid, action, time_ms, fpa_temp, fpa_valid, blocked, input ready);
   modport sink (input valid, action, time_ms, fpa_temp, fpa_valid, blocked, output ready);
endinterface

/* rtl/rtp_rsp_if.sv */
// Result channel carrying the request decision, drift and time since calibration.
interface rtp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               request;
   logic [rtp_pkg::CAUSE_W-1:0]        cause;
   logic signed [rtp_pkg::DRIFT_W-1:0] drift;
   logic [rtp_pkg::TIME_W-1:0]         since_cal_ms;

   modport source (output valid, request, cause, drift, since_cal_ms, input ready);
   modport sink (input valid, request, cause, drift, since_cal_ms, output ready);
endinterface

/* rtl/rtp_csr.sv */
// Configuration register file behind the APB-style port.
module rtp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rtp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [rtp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [rtp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                          pready,
   output rtp_pkg::cfg_type              cfg
);
   import rtp_pkg::*;

   localparam cfg_type CFG_RESET = '{
      policy_enabled:    1'b1,
      inv_time_constant: 22'd210,
      min_interval_ms:   32'd30000,
      max_interval_ms:   32'd300000,
      after_lockout_ms:  32'd5000,
      retry_ms:          32'd10000,
      drift_threshold:   15'd128
   };

   cfg_type                cfg_ff;
   logic [REG_INDEX_W-1:0] reg_index;
   logic                   write_en;

   assign reg_index = paddr[CSR_ADDR_W-1:2];
   assign pready    = 1'b1;
   assign write_en  = psel && penable && pwrite && pready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (write_en) begin
         unique case (reg_index)
            REG_POLICY_ENABLED:    cfg_ff.policy_enabled    <= pwdata[0];
            REG_INV_TIME_CONSTANT: cfg_ff.inv_time_constant <= pwdata[ITC_W-1:0];
            REG_MIN_INTERVAL:      cfg_ff.min_interval_ms   <= pwdata[TIME_W-1:0];
            REG_MAX_INTERVAL:      cfg_ff.max_interval_ms   <= pwdata[TIME_W-1:0];
            REG_AFTER_LOCKOUT:     cfg_ff.after_lockout_ms  <= pwdata[TIME_W-1:0];
            REG_RETRY:             cfg_ff.retry_ms          <= pwdata[TIME_W-1:0];
            REG_DRIFT_THRESHOLD:   cfg_ff.drift_threshold   <= pwdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_POLICY_ENABLED:    prdata = CSR_DATA_W'(cfg_ff.policy_enabled);
         REG_INV_TIME_CONSTANT: prdata = CSR_DATA_W'(cfg_ff.inv_time_constant);
         REG_MIN_INTERVAL:      prdata = CSR_DATA_W'(cfg_ff.min_interval_ms);
         REG_MAX_INTERVAL:      prdata = CSR_DATA_W'(cfg_ff.max_interval_ms);
         REG_AFTER_LOCKOUT:     prdata = CSR_DATA_W'(cfg_ff.after_lockout_ms);
         REG_RETRY:             prdata = CSR_DATA_W'(cfg_ff.retry_ms);
         REG_DRIFT_THRESHOLD:   prdata = CSR_DATA_W'(cfg_ff.drift_threshold);
         default:               prdata = '0;
      endcase
   end

endmodule

/* rtl/rtp_ctrl.sv */
// Sequencer that steps one item through the datapath stages.
module rtp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rtp_pkg::dp_sts_type sts,
   output rtp_pkg::dp_cmd_type cmd
);
   import rtp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INDEX,
      S_WEIGHT,
      S_BLEND,
      S_APPLY,
      S_CHECK,
      S_DECIDE
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // Events, frames without a usable reading and first readings need no smoothing weight.
               state_in = sts.blend_path ? S_INDEX : S_APPLY;
            end
         end
         S_INDEX:  state_in = S_WEIGHT;
         S_WEIGHT: state_in = S_BLEND;
         S_BLEND:  state_in = S_APPLY;
         S_APPLY:  state_in = S_CHECK;
         S_CHECK:  state_in = S_DECIDE;
         S_DECIDE: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign cmd.load      = (state_ff == S_IDLE) && req_valid;
   assign cmd.index_mul = (state_ff == S_INDEX);
   assign cmd.weight_rd = (state_ff == S_WEIGHT);
   assign cmd.blend_mul = (state_ff == S_BLEND);
   assign cmd.apply     = (state_ff == S_APPLY);
   assign cmd.check     = (state_ff == S_CHECK);
   assign cmd.finish    = (state_ff == S_DECIDE) && sts.out_free;

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_valid) |=> (state_ff == S_IDLE))
      else $error("sequencer left idle without an input beat");

   a_short_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid && !sts.blend_path) |=> (state_ff == S_APPLY))
      else $error("item without blending did not go straight to apply");

   a_decide_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE && sts.out_free) |=> (state_ff == S_IDLE))
      else $error("sequencer did not return to idle after writing a result");

endmodule

/* rtl/rtp_datapath.sv */
// Smoothing, hold-off timers and request decision for the trigger policy.
module rtp_datapath #(
   parameter int WEIGHT_TABLE_DEPTH = rtp_pkg::WEIGHT_TABLE_DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rtp_pkg::cfg_type                   cfg,
   input  rtp_pkg::dp_cmd_type                cmd,
   output rtp_pkg::dp_sts_type                sts,
   input  logic [rtp_pkg::ACTION_W-1:0]       req_action,
   input  logic [rtp_pkg::TIME_W-1:0]         req_time_ms,
   input  logic signed [rtp_pkg::TEMP_W-1:0]  req_fpa_temp,
   input  logic                               req_fpa_valid,
   input  logic                               req_blocked,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_request,
   output logic [rtp_pkg::CAUSE_W-1:0]        rsp_cause,
   output logic signed [rtp_pkg::DRIFT_W-1:0] rsp_drift,
   output logic [rtp_pkg::TIME_W-1:0]         rsp_since_cal_ms
);
   import rtp_pkg::*;

   localparam int IDX_W      = (WEIGHT_TABLE_DEPTH > 1) ? $clog2(WEIGHT_TABLE_DEPTH) : 1;
   localparam int FRAC_W     = 16;
   localparam int IDX_PROD_W = TIME_W + ITC_W;
   localparam int IDX_HI_W   = IDX_PROD_W - FRAC_W;
   localparam int DIFF_W     = TIME_W + 1;
   localparam int BLEND_W    = DIFF_W + WEIGHT_W + 1;
   localparam int MAG_W      = DRIFT_W + 1;
   localparam logic [63:0] EXP_STEP_Q30 = 64'd1040706261;
   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

   typedef logic [WEIGHT_W-1:0] weight_rom_type [WEIGHT_TABLE_DEPTH];

   // Entry i is 1 - exp(-i/32) in Q16, built from repeated Q30 products.
   function automatic weight_rom_type build_weight_rom();
      weight_rom_type rom;
      logic [63:0]    p;
      logic [63:0]    q;
      int             i;
      p = 64'd1 << 30;
      for (i = 0; i < WEIGHT_TABLE_DEPTH; i++) begin
         q      = (p + 64'd8192) >> 14;
         rom[i] = WEIGHT_W'(64'd65536 - q);
         p      = (p * EXP_STEP_Q30 + (64'd1 << 29)) >> 30;
      end
      return rom;
   endfunction

   localparam weight_rom_type WEIGHT_ROM = build_weight_rom();

   // Item registers.
   logic [ACTION_W-1:0]      act_ff;
   logic [TIME_W-1:0]        time_ff;
   logic signed [TEMP_W-1:0] temp_ff;
   logic                     fvalid_ff;
   logic                     blocked_ff;
   logic                     blend_ff;
   logic [TIME_W-1:0]        dt_ff;
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [DIFF_W-1:0] diff_in;

   // Arithmetic pipeline registers.
   logic [IDX_PROD_W-1:0]     idx_prod_ff;
   logic [IDX_PROD_W-1:0]     idx_prod_in;
   logic [IDX_HI_W-1:0]       idx_hi;
   logic [IDX_W-1:0]          rom_addr;
   logic                      idx_in_range;
   logic [WEIGHT_W-1:0]       weight_ff;
   logic signed [BLEND_W-1:0] blend_prod_ff;
   logic signed [BLEND_W-1:0] blend_prod_in;
   logic signed [BLEND_W-1:0] blend_round;

   // Policy state.
   logic signed [TIME_W-1:0] smoothed_ff;
   logic                     smoothed_valid_ff;
   logic [TIME_W-1:0]        last_frame_time_ff;
   logic                     last_frame_valid_ff;
   logic [TIME_W-1:0]        cal_time_ff;
   logic signed [TEMP_W-1:0] cal_temp_ff;
   logic                     cal_valid_ff;
   logic [TIME_W-1:0]        lockout_end_ff;
   logic                     lockout_valid_ff;
   logic [TIME_W-1:0]        request_time_ff;
   logic                     request_valid_ff;
   logic signed [TIME_W-1:0] target;
   logic signed [TIME_W-1:0] smoothed_blend;

   // Check stage.
   logic [DIFF_W-1:0]         sm_round_sum;
   logic signed [DRIFT_W-1:0] drift_ff;
   logic signed [DRIFT_W-1:0] drift_in;
   logic                      hold_ff;
   logic                      hold_in;
   logic                      maxed_ff;
   logic [TIME_W-1:0]         since_ff;
   logic [TIME_W-1:0]         since_in;
   logic [TIME_W-1:0]         lockout_el;
   logic [TIME_W-1:0]         retry_el;

   // Decision.
   logic signed [MAG_W-1:0] drift_ext;
   logic [MAG_W-1:0]        drift_mag;
   logic                    drift_hit;
   logic                    qualify;
   cause_type               cause_in;
   logic                    request_in;

   // Result register.
   logic                      rsp_valid_ff;
   logic                      rsp_request_ff;
   cause_type                 rsp_cause_ff;
   logic signed [DRIFT_W-1:0] rsp_drift_ff;
   logic [TIME_W-1:0]         rsp_since_ff;

   assign sts.blend_path = (req_action == ACT_FRAME) && req_fpa_valid
                           && smoothed_valid_ff && last_frame_valid_ff;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   assign diff_in = $signed({req_fpa_temp[TEMP_W-1], req_fpa_temp, 16'b0})
                    - $signed({smoothed_ff[TIME_W-1], smoothed_ff});

   assign idx_prod_in   = IDX_PROD_W'(dt_ff) * IDX_PROD_W'(cfg.inv_time_constant);
   assign idx_hi        = idx_prod_ff[IDX_PROD_W-1:FRAC_W];
   assign idx_in_range  = idx_hi < IDX_HI_W'(WEIGHT_TABLE_DEPTH);
   assign rom_addr      = idx_prod_ff[FRAC_W +: IDX_W];
   assign blend_prod_in = $signed({1'b0, weight_ff}) * diff_ff;

   // Adding half an LSB then keeping bits above the fraction rounds to nearest, ties upward.
   assign blend_round    = blend_prod_ff + $signed(BLEND_W'(32768));
   assign smoothed_blend = smoothed_ff + $signed(blend_round[FRAC_W +: TIME_W]);
   assign target         = $signed({temp_ff, 16'b0});

   assign sm_round_sum = {smoothed_ff[TIME_W-1], smoothed_ff} + DIFF_W'(32768);
   assign drift_in     = $signed(sm_round_sum[DIFF_W-1:FRAC_W]
                                 - {cal_temp_ff[TEMP_W-1], cal_temp_ff});
   assign since_in     = time_ff - cal_time_ff;
   assign lockout_el   = time_ff - lockout_end_ff;
   assign retry_el     = time_ff - request_time_ff;
   assign hold_in      = (since_in < cfg.min_interval_ms)
                         || (lockout_valid_ff && (lockout_el < cfg.after_lockout_ms))
                         || (request_valid_ff && (retry_el < cfg.retry_ms));

   assign drift_ext  = {drift_ff[DRIFT_W-1], drift_ff};
   assign drift_mag  = drift_ext[MAG_W-1] ? MAG_W'(-drift_ext) : MAG_W'(drift_ext);
   assign drift_hit  = drift_mag >= MAG_W'(cfg.drift_threshold);
   assign qualify    = (act_ff == ACT_FRAME) && cfg.policy_enabled && !blocked_ff
                       && cal_valid_ff && smoothed_valid_ff && !hold_ff;

   always_comb begin
      cause_in = CAUSE_NONE;
      if (qualify) begin
         if (drift_hit) begin
            cause_in = CAUSE_DRIFT;
         end else if (maxed_ff) begin
            cause_in = CAUSE_MAX_INTERVAL;
         end
      end
   end

   assign request_in = (cause_in != CAUSE_NONE);

   // Item capture and arithmetic pipeline.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff     <= req_action;
         time_ff    <= req_time_ms;
         temp_ff    <= req_fpa_temp;
         fvalid_ff  <= req_fpa_valid;
         blocked_ff <= req_blocked;
         blend_ff   <= sts.blend_path;
         dt_ff      <= req_time_ms - last_frame_time_ff;
         diff_ff    <= diff_in;
      end
      if (cmd.index_mul) begin
         idx_prod_ff <= idx_prod_in;
      end
      if (cmd.weight_rd) begin
         weight_ff <= idx_in_range ? WEIGHT_ROM[rom_addr] : WEIGHT_ONE;
      end
      if (cmd.blend_mul) begin
         blend_prod_ff <= blend_prod_in;
      end
      if (cmd.check) begin
         drift_ff <= drift_in;
         hold_ff  <= hold_in;
         maxed_ff <= since_in >= cfg.max_interval_ms;
         since_ff <= since_in;
      end
   end

   // Policy state.
   always_ff @(posedge clock) begin
      if (reset) begin
         smoothed_ff         <= '0;
         smoothed_valid_ff   <= 1'b0;
         last_frame_time_ff  <= '0;
         last_frame_valid_ff <= 1'b0;
         cal_time_ff         <= '0;
         cal_temp_ff         <= '0;
         cal_valid_ff        <= 1'b0;
         lockout_end_ff      <= '0;
         lockout_valid_ff    <= 1'b0;
         request_time_ff     <= '0;
         request_valid_ff    <= 1'b0;
      end else if (cmd.apply) begin
         unique case (act_ff)
            ACT_CAL_DONE: begin
               cal_time_ff         <= time_ff;
               cal_temp_ff         <= temp_ff;
               cal_valid_ff        <= 1'b1;
               smoothed_ff         <= target;
               smoothed_valid_ff   <= 1'b1;
               last_frame_time_ff  <= time_ff;
               last_frame_valid_ff <= 1'b1;
               request_valid_ff    <= 1'b0;
            end
            ACT_LOCKOUT_END: begin
               lockout_end_ff   <= time_ff;
               lockout_valid_ff <= 1'b1;
            end
            ACT_FRAME: begin
               if (fvalid_ff) begin
                  smoothed_ff         <= blend_ff ? smoothed_blend : target;
                  smoothed_valid_ff   <= 1'b1;
                  last_frame_time_ff  <= time_ff;
                  last_frame_valid_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end else if (cmd.finish && request_in) begin
         request_time_ff  <= time_ff;
         request_valid_ff <= 1'b1;
      end
   end

   // Result register; it keeps its beat until the sink takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_request_ff <= request_in;
         rsp_cause_ff   <= cause_in;
         rsp_drift_ff   <= (cal_valid_ff && smoothed_valid_ff) ? drift_ff : '0;
         rsp_since_ff   <= cal_valid_ff ? since_ff : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_request      = rsp_request_ff;
   assign rsp_cause        = rsp_cause_ff;
   assign rsp_drift        = rsp_drift_ff;
   assign rsp_since_cal_ms = rsp_since_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a beat that was not taken");

   a_request_has_cause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_request_ff) |-> (rsp_cause_ff != CAUSE_NONE))
      else $error("request raised without a cause");

   a_request_recorded: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && request_in) |=>
         (request_valid_ff && request_time_ff == $past(time_ff)))
      else $error("raised request did not arm the retry hold");

endmodule

/* rtl/recalibration_trigger_policy.sv */
// Top level: one frame or event beat in, one decision beat out.
// A frame with a usable reading and earlier smoothing history goes through index multiply,
// weight table read, blend multiply, update, check and decide before its result is written.
// Other items go from acceptance straight to update, check and decide.
// One item is in flight at a time; decide waits while the last result is still untaken.
// Synchronous reset loads register defaults and clears calibration, smoothing, lockout and
// retry history at once; no clearing pass is needed.
module recalibration_trigger_policy #(
   parameter int WEIGHT_TABLE_DEPTH = rtp_pkg::WEIGHT_TABLE_DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   rtp_req_if.sink                        req_chan,
   rtp_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [rtp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rtp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rtp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import rtp_pkg::*;

   cfg_type    cfg;
   dp_cmd_type cmd;
   dp_sts_type sts;

   rtp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   rtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   rtp_datapath #(
      .WEIGHT_TABLE_DEPTH (WEIGHT_TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_chan.action),
      .req_time_ms      (req_chan.time_ms),
      .req_fpa_temp     (req_chan.fpa_temp),
      .req_fpa_valid    (req_chan.fpa_valid),
      .req_blocked      (req_chan.blocked),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_request      (rsp_chan.request),
      .rsp_cause        (rsp_chan.cause),
      .rsp_drift        (rsp_chan.drift),
      .rsp_since_cal_ms (rsp_chan.since_cal_ms)
   );

endmodule
